// ----- hw/rtl/uspq_pkg.sv -----
// ----------------------------------------------------------------------------
// uspq_pkg
// Shared widths and the classified operation type of the slot priority queue.
// ----------------------------------------------------------------------------
package uspq_pkg;

	localparam int PRIO_W  = 16;
	localparam int PAY_W   = 32;
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = 1;
	localparam int QCNT_W  = 2;

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	typedef struct packed {
		logic              is_pop;
		logic              zero_prio;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  payload;
	} op_t;

	typedef struct packed {
		logic valid;
		op_t  op;
	} op_chan_t;

endpackage

// ----- hw/rtl/uspq_in_if.sv -----
// ----------------------------------------------------------------------------
// uspq_in_if
// Request channel: operation kind, priority and payload tag.
// ----------------------------------------------------------------------------
interface uspq_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] priority_req;
	logic [31:0] payload;

	modport source (output valid, output kind, output priority_req, output payload,
		input ready);
	modport sink (input valid, input kind, input priority_req, input payload,
		output ready);
endinterface

// ----- hw/rtl/uspq_out_if.sv -----
// ----------------------------------------------------------------------------
// uspq_out_if
// Response channel: status, popped priority and popped payload tag.
// ----------------------------------------------------------------------------
interface uspq_out_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [15:0] out_priority;
	logic [31:0] out_payload;

	modport source (output valid, output ok, output out_priority, output out_payload,
		input ready);
	modport sink (input valid, input ok, input out_priority, input out_payload,
		output ready);
endinterface

// ----- hw/rtl/uspq_front.sv -----
// ----------------------------------------------------------------------------
// uspq_front
// Accepts request transactions, classifies them and holds them in a short
// queue for the back end.
// ----------------------------------------------------------------------------
module uspq_front (
	input  logic            clk,
	input  logic            arst_n,
	uspq_in_if.sink         req,
	output uspq_pkg::op_chan_t op_chan,
	input  logic            op_ready
);
	import uspq_pkg::*;

	op_t               fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push_en;
	logic              pop_en;
	op_t               op_in;

	assign req.ready = (count_q != QCNT_W'(QDEPTH));
	assign push_en   = req.valid && req.ready;
	assign pop_en    = op_chan.valid && op_ready;

	always_comb begin
		op_in.is_pop    = (req.kind == KIND_POP);
		op_in.zero_prio = (req.priority_req == '0);
		op_in.prio      = req.priority_req;
		op_in.payload   = req.payload;
	end

	assign op_chan.valid = (count_q != '0);
	assign op_chan.op    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			fifo_q[wr_ptr_q] <= op_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push_en, pop_en})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- hw/rtl/uspq_back.sv -----
// ----------------------------------------------------------------------------
// uspq_back
// Slot storage and sequencer: scans the used slots one per cycle, then
// performs the push or pop and registers the response.
// ----------------------------------------------------------------------------
module uspq_back #(
	parameter int SLOTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  uspq_pkg::op_chan_t op_chan,
	output logic               op_ready,
	uspq_out_if.source         rsp
);
	import uspq_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SCAN = 6'b000010,
		ST_LAST = 6'b000100,
		ST_FIN  = 6'b001000,
		ST_POPD = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [PRIO_W-1:0] prio_mem [SLOTS];
	logic [PAY_W-1:0]  pay_mem  [SLOTS];
	logic [SLOTS-1:0]  valid_q;
	logic [CW-1:0]     used_q;
	logic [IW-1:0]     idx_q;
	logic              cmp_valid_s1;
	logic [IW-1:0]     cmp_idx_s1;
	logic [PRIO_W-1:0] prio_rd_s1;
	logic [PAY_W-1:0]  pay_rd_q;
	logic [PRIO_W-1:0] best_prio_q;
	logic [IW-1:0]     best_idx_q;
	logic              free_found_q;
	logic [IW-1:0]     free_idx_q;
	logic              res_ok_q;
	logic [PRIO_W-1:0] res_prio_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic              out_valid_q;
	logic              out_ok_q;
	logic [PRIO_W-1:0] out_prio_q;
	logic [PAY_W-1:0]  out_pay_q;

	logic              cmp_slot_valid;
	logic [PRIO_W-1:0] cmp_prio;
	logic              is_last;
	logic              wr_en;
	logic [IW-1:0]     wr_idx;
	logic              push_append;
	logic              out_free;

	assign op_ready       = (state_q == ST_IDLE);
	assign cmp_slot_valid = valid_q[cmp_idx_s1];
	assign cmp_prio       = cmp_slot_valid ? prio_rd_s1 : '0;
	assign is_last        = (CW'(idx_q) == used_q - CW'(1));
	assign out_free       = !out_valid_q || rsp.ready;

	// push slot choice: highest free slot below the count, else append
	always_comb begin
		push_append = 1'b0;
		wr_en       = 1'b0;
		wr_idx      = free_idx_q;
		if (state_q == ST_FIN && !op_q.is_pop && !op_q.zero_prio) begin
			if (free_found_q) begin
				wr_en = 1'b1;
			end else if (used_q != CW'(SLOTS)) begin
				wr_en       = 1'b1;
				push_append = 1'b1;
				wr_idx      = used_q[IW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		prio_rd_s1 <= prio_mem[idx_q];
		pay_rd_q   <= pay_mem[best_idx_q];
		if (wr_en) begin
			prio_mem[wr_idx] <= op_q.prio;
			pay_mem[wr_idx]  <= op_q.payload;
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= idx_q;
		case (state_q)
			ST_IDLE: begin
				op_q         <= op_chan.op;
				best_prio_q  <= '0;
				best_idx_q   <= '0;
				free_idx_q   <= '0;
			end
			ST_FIN: begin
				res_ok_q   <= wr_en || (op_q.is_pop && best_prio_q != '0);
				res_prio_q <= op_q.is_pop ? best_prio_q : '0;
				res_pay_q  <= '0;
			end
			ST_POPD: begin
				res_pay_q <= pay_rd_q;
			end
			default: begin
			end
		endcase
		if (cmp_valid_s1) begin
			if (cmp_prio > best_prio_q) begin
				best_prio_q <= cmp_prio;
				best_idx_q  <= cmp_idx_s1;
			end
			if (!cmp_slot_valid) begin
				free_idx_q <= cmp_idx_s1;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_ok_q   <= res_ok_q;
			out_prio_q <= res_prio_q;
			out_pay_q  <= res_pay_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			used_q       <= '0;
			idx_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmp_valid_s1 && !cmp_slot_valid) begin
				free_found_q <= 1'b1;
			end
			if (rsp.ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cmp_valid_s1 <= 1'b0;
					free_found_q <= 1'b0;
					idx_q        <= '0;
					if (op_chan.valid) begin
						state_q <= (used_q == '0) ? ST_FIN : ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_valid_s1 <= 1'b1;
					if (is_last) begin
						state_q <= ST_LAST;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				ST_LAST: begin
					cmp_valid_s1 <= 1'b0;
					state_q      <= ST_FIN;
				end
				ST_FIN: begin
					if (wr_en) begin
						valid_q[wr_idx] <= 1'b1;
					end
					if (push_append) begin
						used_q <= used_q + CW'(1);
					end
					if (op_q.is_pop && best_prio_q != '0) begin
						valid_q[best_idx_q] <= 1'b0;
						state_q             <= ST_POPD;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_POPD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.ok           = out_ok_q;
	assign rsp.out_priority = out_prio_q;
	assign rsp.out_payload  = out_pay_q;

endmodule

// ----- hw/rtl/unsorted_slot_priority_queue.sv -----
// sequence: after acceptance a request steps through ST_SCAN and ST_LAST (both
// skipped when no slot is used yet), ST_FIN, ST_POPD (successful pop only) and ST_DONE
// throughput: the sequencer takes a new transaction only in ST_IDLE, so one at a time;
// the scan reads one slot per cycle over the priority memory read port, and ST_DONE waits while the response is held
// reset: all slots free, used count zero, two-entry request queue empty;
// payload memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// unsorted_slot_priority_queue
// Max priority queue over an unsorted array of slots, with a request queue
// in front of a scanning sequencer.
// ----------------------------------------------------------------------------
module unsorted_slot_priority_queue #(
	parameter int SLOTS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	uspq_in_if.sink    req,
	uspq_out_if.source rsp
);
	import uspq_pkg::*;

	op_chan_t op_chan;
	logic     op_ready;

	uspq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.op_chan  (op_chan),
		.op_ready (op_ready)
	);

	uspq_back #(
		.SLOTS (SLOTS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_chan  (op_chan),
		.op_ready (op_ready),
		.rsp      (rsp)
	);

endmodule

// ----- bench/tb_unsorted_slot_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unsorted_slot_priority_queue
// Self-checking bench for the slot priority queue. A short directed table
// walks through the empty, full, zero priority and tie cases. Random push/pop
// traffic follows, with phases that lean toward filling, balancing or draining the
// queue. Every response is checked against a behavioral copy of the slot
// array or an expected table entry, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_unsorted_slot_priority_queue;
	import uspq_pkg::*;

	localparam int NUM_SLOTS    = 8;
	localparam int RANDOM_ITEMS = 1126;
	localparam int CALM_TAIL    = 150;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 1000;

	typedef struct packed {
		logic              ok;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
	} resp_t;

	typedef struct {
		logic              kind;
		logic [PRIO_W-1:0] prio;
		logic [PAY_W-1:0]  pay;
		bit                typed;
		resp_t             want;
	} row_t;

	logic clk;
	logic arst_n;

	uspq_in_if  req ();
	uspq_out_if rsp ();

	unsorted_slot_priority_queue #(
		.SLOTS(NUM_SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// behavioral copy of the slot array
	logic [PRIO_W-1:0] slot_prio [NUM_SLOTS];
	logic [PAY_W-1:0]  slot_pay  [NUM_SLOTS];
	int unsigned       used_slots;

	resp_t pending_resp [$];
	row_t  plan [$];

	int mismatches;
	int idle_cycles;
	bit calm;
	int n_push, n_push_refused, n_pop, n_pop_empty, n_checked;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic resp_t apply_queue_op(logic kind, logic [PRIO_W-1:0] p,
		logic [PAY_W-1:0] d);
		resp_t             r;
		int                i;
		int                best;
		logic [PRIO_W-1:0] best_p;
		bit                done;
		r = '0;
		if (kind == KIND_PUSH) begin
			if (p != '0) begin
				done = 1'b0;
				for (i = int'(used_slots); i > 0 && !done; i--) begin
					if (slot_prio[i-1] == '0) begin
						slot_prio[i-1] = p;
						slot_pay[i-1]  = d;
						done = 1'b1;
					end
				end
				if (!done && used_slots < NUM_SLOTS) begin
					slot_prio[used_slots] = p;
					slot_pay[used_slots]  = d;
					used_slots++;
					done = 1'b1;
				end
				r.ok = done;
			end
		end else begin
			best   = 0;
			best_p = '0;
			for (i = 0; i < int'(used_slots); i++) begin
				if (slot_prio[i] > best_p) begin
					best_p = slot_prio[i];
					best   = i;
				end
			end
			if (best_p != '0) begin
				r.ok   = 1'b1;
				r.prio = best_p;
				r.pay  = slot_pay[best];
				slot_prio[best] = '0;
				slot_pay[best]  = '0;
			end
		end
		return r;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic send_req(logic k, logic [PRIO_W-1:0] p, logic [PAY_W-1:0] d,
		bit typed, resp_t want);
		resp_t pred;
		int    gap;
		req.valid        <= 1'b1;
		req.kind         <= k;
		req.priority_req <= p;
		req.payload      <= d;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		pred = apply_queue_op(k, p, d);
		pending_resp.push_back(typed ? want : pred);
		if (k == KIND_PUSH) begin
			n_push++;
			if (!pred.ok) n_push_refused++;
		end else begin
			n_pop++;
			if (!pred.ok) n_pop_empty++;
		end
		if (!calm && $urandom_range(0, 99) < 20) begin
			gap = $urandom_range(1, 16);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// response check
	always @(posedge clk) begin : rsp_check
		resp_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_resp.size() == 0) begin
				flag_mismatch("response with no request outstanding");
			end else begin
				want = pending_resp.pop_front();
				n_checked++;
				if (rsp.ok !== want.ok)
					flag_mismatch($sformatf("ok %b, want %b", rsp.ok, want.ok));
				if (rsp.out_priority !== want.prio)
					flag_mismatch($sformatf("out_priority %h, want %h",
						rsp.out_priority, want.prio));
				if (rsp.out_payload !== want.pay)
					flag_mismatch($sformatf("out_payload %h, want %h",
						rsp.out_payload, want.pay));
			end
		end
	end

	// receiver stalls
	initial begin : rsp_stall
		int stall_left;
		stall_left = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!calm && stall_left == 0 && $urandom_range(0, 99) < 8)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: %0d responses still outstanding", pending_resp.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                n;
		int                push_pct;
		logic              k;
		logic [PRIO_W-1:0] p;
		resp_t             none;
		row_t              r;

		none             = '0;
		mismatches       = 0;
		idle_cycles      = 0;
		calm             = 1'b0;
		n_push           = 0;
		n_push_refused   = 0;
		n_pop            = 0;
		n_pop_empty      = 0;
		n_checked        = 0;
		used_slots       = 0;
		push_pct         = 50;
		for (n = 0; n < NUM_SLOTS; n++) begin
			slot_prio[n] = '0;
			slot_pay[n]  = '0;
		end

		req.valid        = 1'b0;
		req.kind         = KIND_PUSH;
		req.priority_req = '0;
		req.payload      = '0;
		arst_n           = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty, zero priority, extremes, ties, full, drain
		plan.push_back('{KIND_POP,  16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 16'h0, 32'h0}});
		plan.push_back('{KIND_PUSH, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'h0, 32'h0}});
		plan.push_back('{KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b1, 16'h0, 32'h0}});
		plan.push_back('{KIND_POP,  16'h0000, 32'h0000_0000, 1'b1,
			'{1'b1, 16'hFFFF, 32'hFFFF_FFFF}});
		plan.push_back('{KIND_POP,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{1'b0, 16'h0, 32'h0}});
		plan.push_back('{KIND_PUSH, 16'h0001, 32'h0000_0000, 1'b1, '{1'b1, 16'h0, 32'h0}});
		plan.push_back('{KIND_PUSH, 16'h8000, 32'hA5A5_A5A5, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h8000, 32'h5A5A_5A5A, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h8000, 32'h0000_FFFF, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h7FFF, 32'hFFFF_0000, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'hFFFF, 32'h1234_5678, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h0001, 32'h8765_4321, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h1234, 32'hDEAD_BEEF, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h5555, 32'h0F0F_0F0F, 1'b1, '{1'b0, 16'h0, 32'h0}});
		plan.push_back('{KIND_POP,  16'h0000, 32'h0000_0000, 1'b0, none});
		plan.push_back('{KIND_POP,  16'h0000, 32'h0000_0000, 1'b0, none});
		plan.push_back('{KIND_PUSH, 16'h9000, 32'hF0F0_F0F0, 1'b0, none});
		for (n = 0; n < 7; n++)
			plan.push_back('{KIND_POP, 16'h0000, 32'h0000_0000, 1'b0, none});
		plan.push_back('{KIND_POP,  16'h0000, 32'h0000_0000, 1'b1, '{1'b0, 16'h0, 32'h0}});

		foreach (plan[i]) begin
			r = plan[i];
			send_req(r.kind, r.prio, r.pay, r.typed, r.want);
		end

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// phases that lean toward filling, balancing or draining
			if (n % 100 == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 80;
				endcase
			end
			calm = (n >= RANDOM_ITEMS - CALM_TAIL);
			k = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
			case ($urandom_range(0, 19))
				0: p = '0;
				1: p = 16'hFFFF;
				2, 3, 4, 5, 6, 7, 8, 9: p = PRIO_W'($urandom_range(1, 4));
				default: p = PRIO_W'($urandom);
			endcase
			send_req(k, p, PAY_W'($urandom), 1'b0, none);
		end
		req.valid <= 1'b0;

		while (pending_resp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d pushes (%0d refused), %0d pops (%0d on empty)",
			n_push + n_pop, n_push, n_push_refused, n_pop, n_pop_empty);
		$display("%0d responses checked, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
